// ----- rtl/isr_pkg.sv -----
// Package for the Indic syllable reorder block.
// Category and phase codes, the stored entry type and the classifier.
// No dependencies.
package isr_pkg;

  typedef enum logic [3:0] {
    CAT_OTHER  = 4'd0,
    CAT_CONS   = 4'd1,
    CAT_RA     = 4'd2,
    CAT_VOWEL  = 4'd3,
    CAT_VIRAMA = 4'd4,
    CAT_NUKTA  = 4'd5,
    CAT_MPRE   = 4'd6,
    CAT_MPOST  = 4'd7,
    CAT_MABOVE = 4'd8,
    CAT_MBELOW = 4'd9,
    CAT_BINDU  = 4'd10
  } cat_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PRE   = 2'd1,
    PH_CONS  = 2'd2,
    PH_MARKS = 2'd3
  } ph_t;

  typedef enum logic [1:0] {
    ST_IN,
    ST_FLUSH,
    ST_ITEM
  } st_t;

  typedef enum logic [1:0] {
    FATE_NONE,
    FATE_EMIT,
    FATE_WRITE
  } fate_t;

  typedef struct packed {
    logic [20:0]        code_point;
    logic [15:0]        glyph_id;
    logic signed [15:0] advance;
    logic [15:0]        cluster_index;
  } entry_t;

  localparam logic [20:0] INDIC_LO = 21'h000900;
  localparam logic [20:0] INDIC_HI = 21'h000D7F;
  localparam logic [20:0] DEVA_HI  = 21'h00097F;
  localparam logic [20:0] BLK_BASE = 21'h000980;

  localparam logic [6:0] PRE_MATRA_OFS [8] = '{
    7'h3F, 7'h3F, 7'h3F, 7'h47, 7'h46, 7'h3F, 7'h3F, 7'h46
  };

  function automatic logic is_cons(cat_t c);
    return (c == CAT_CONS) || (c == CAT_RA);
  endfunction

  function automatic logic is_mark(cat_t c);
    return (c == CAT_MPRE) || (c == CAT_MPOST) || (c == CAT_MABOVE) ||
           (c == CAT_MBELOW) || (c == CAT_BINDU);
  endfunction

  function automatic ph_t start_phase(cat_t c);
    return (is_cons(c) || c == CAT_VOWEL) ? PH_CONS : PH_PRE;
  endfunction

  function automatic logic in_indic(logic [20:0] cp);
    return (cp >= INDIC_LO) && (cp <= INDIC_HI);
  endfunction

  function automatic cat_t classify(logic [20:0] cp);
    logic [20:0] rel;
    logic [2:0]  blk;
    logic [6:0]  off;
    cat_t        c;
    rel = cp - BLK_BASE;
    blk = rel[9:7];
    off = cp[6:0];
    c   = CAT_OTHER;
    if (cp >= INDIC_LO && cp <= DEVA_HI) begin
      if (off == 7'h30 || off == 7'h31) c = CAT_RA;
      else if (off == 7'h4D) c = CAT_VIRAMA;
      else if (off == 7'h3C) c = CAT_NUKTA;
      else if (off == 7'h3F) c = CAT_MPRE;
      else if (off == 7'h40 || off == 7'h3E || (off >= 7'h49 && off <= 7'h4C)) c = CAT_MPOST;
      else if (off >= 7'h45 && off <= 7'h48) c = CAT_MABOVE;
      else if (off >= 7'h41 && off <= 7'h44) c = CAT_MBELOW;
      else if (off >= 7'h01 && off <= 7'h03) c = CAT_BINDU;
      else if (off >= 7'h05 && off <= 7'h14) c = CAT_VOWEL;
      else if ((off >= 7'h15 && off <= 7'h39) || (off >= 7'h58 && off <= 7'h5F) ||
               (off >= 7'h78)) c = CAT_CONS;
    end else if (cp >= BLK_BASE && cp <= INDIC_HI) begin
      if (off == PRE_MATRA_OFS[blk]) c = CAT_MPRE;
      else if (off == 7'h4D) c = CAT_VIRAMA;
      else if (off == 7'h30) c = CAT_RA;
      else if (off == 7'h3C) c = CAT_NUKTA;
      else if (off >= 7'h3E && off <= 7'h4C) c = CAT_MPOST;
      else if (off >= 7'h01 && off <= 7'h03) c = CAT_BINDU;
      else if (off >= 7'h05 && off <= 7'h14) c = CAT_VOWEL;
      else if (off >= 7'h15 && off <= 7'h39) c = CAT_CONS;
    end
    return c;
  endfunction

endpackage

// ----- rtl/isr_in_if.sv -----
// Input channel of the Indic syllable reorder block.
// Valid/ready handshake with one shaped character per request. No dependencies.
interface isr_in_if;
  logic               valid;
  logic               ready;
  logic [20:0]        code_point;
  logic [15:0]        glyph_id;
  logic signed [15:0] advance;
  logic [15:0]        cluster_index;
  logic               end_of_text;

  modport source(output valid, code_point, glyph_id, advance, cluster_index, end_of_text,
                 input ready);
  modport sink(input valid, code_point, glyph_id, advance, cluster_index, end_of_text,
               output ready);
endinterface

// ----- rtl/isr_out_if.sv -----
// Result channel of the Indic syllable reorder block.
// Valid/ready handshake with one character in drawing order per request.
interface isr_out_if;
  logic               valid;
  logic               ready;
  logic [20:0]        out_code_point;
  logic [15:0]        out_glyph_id;
  logic signed [15:0] out_advance;
  logic [15:0]        out_cluster_index;
  logic               last_of_burst;
  logic               run_end;
  logic               run_moved;

  modport source(output valid, out_code_point, out_glyph_id, out_advance, out_cluster_index,
                 last_of_burst, run_end, run_moved, input ready);
  modport sink(input valid, out_code_point, out_glyph_id, out_advance, out_cluster_index,
               last_of_burst, run_end, run_moved, output ready);
endinterface

// ----- rtl/indic_syllable_reorder_core.sv -----
// Indic syllable reorder, top level.
// Depends on isr_pkg, isr_in_if and isr_out_if.
//
// Usage: shaped characters enter on in_ch, one per request; results leave on
// out_ch in drawing order. Non-Indic characters pass straight through. Indic
// characters are parsed into syllables and held in a syllable memory; the
// character that closes a syllable (or end_of_text) causes the held syllable
// to be sent out reordered, with last_of_burst on the final result of that
// request and run_end/run_moved on the final result of the run.
// A character that only extends a syllable is stored and in_ch stays ready.
// A character that flushes a syllable holds off in_ch while the syllable is
// read back from the memory, one entry per cycle while the output register
// is free, through a registered read; in_ch is also held off while a
// pass-through or single-character result is sent. Reorder decisions are
// tracked as characters are stored, so no search pass is needed at flush time.
// Stall: a result waits in the output register while out_ch.ready is low and
// the memory read-out pauses with it. No result is dropped.
// Reset: synchronous, active low; the block comes up idle with no open
// syllable and no pending result. The memory needs no clearing.
module indic_syllable_reorder_core #(
  parameter int MAX_SYLLABLE = 32
) (
  input logic    clk,
  input logic    rst_n,
  isr_in_if.sink    in_ch,
  isr_out_if.source out_ch
);
  import isr_pkg::*;

  localparam int CNT_W = $clog2(MAX_SYLLABLE + 1);
  localparam int IDX_W = $clog2(MAX_SYLLABLE);
  localparam int PW    = CNT_W + 1;

  entry_t mem [MAX_SYLLABLE];
  entry_t rdata_r;

  st_t  st_r, st_nxt;
  ph_t  ph_r, ph_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic moved_r, moved_nxt;

  logic cat0ra_r, cat0ra_nxt;
  logic cat1vir_r, cat1vir_nxt;
  logic reph_r, reph_nxt;
  logic pend_r, pend_nxt;
  logic base_r, base_nxt;
  logic mpre_r, mpre_nxt;
  logic [IDX_W-1:0] mpre_idx_r, mpre_idx_nxt;

  entry_t hold_r, hold_nxt;
  cat_t   hold_cat_r, hold_cat_nxt;
  fate_t  fate_r, fate_nxt;
  logic   eot_r, eot_nxt;

  logic [PW-1:0] rpos_r, rpos_nxt;
  logic have_r, have_nxt;

  logic   ov_r, ov_nxt;
  entry_t ob_r, ob_nxt;
  logic   olast_r, olast_nxt;
  logic   oend_r, oend_nxt;
  logic   omoved_r, omoved_nxt;

  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t wr_data;
  logic [IDX_W-1:0] rd_addr;

  logic app_en, app_fresh;
  cat_t app_cat;
  logic [CNT_W-1:0] app_k;

  cat_t   in_cat;
  entry_t in_entry;
  logic   cont, taken, acc;
  ph_t    cont_ph;
  fate_t  in_fate;

  logic found, reph_eff, fl_moved, slot_free, ld, more, issue, fl_done, it_done;
  logic [PW-1:0] n_w, ix;

  // Input decode
  always_comb begin
    in_cat   = classify(in_ch.code_point);
    in_entry = '{code_point: in_ch.code_point, glyph_id: in_ch.glyph_id,
                 advance: in_ch.advance, cluster_index: in_ch.cluster_index};
    cont     = 1'b0;
    cont_ph  = ph_r;
    case (ph_r)
      PH_PRE: begin
        cont    = (in_cat != CAT_OTHER);
        cont_ph = (is_cons(in_cat) || in_cat == CAT_VOWEL) ? PH_CONS : PH_PRE;
      end
      PH_CONS: begin
        cont    = (in_cat == CAT_NUKTA) || (in_cat == CAT_VIRAMA) || is_mark(in_cat);
        cont_ph = (in_cat == CAT_NUKTA) ? PH_CONS :
                  ((in_cat == CAT_VIRAMA) ? PH_PRE : PH_MARKS);
      end
      PH_MARKS: begin
        cont    = is_mark(in_cat) || (in_cat == CAT_NUKTA);
        cont_ph = PH_MARKS;
      end
      default: begin
        cont    = 1'b0;
        cont_ph = ph_r;
      end
    endcase
    acc     = in_ch.valid && (st_r == ST_IN);
    taken   = (ph_r != PH_IDLE) && cont && (cnt_r < CNT_W'(MAX_SYLLABLE));
    in_fate = (!in_indic(in_ch.code_point) || in_cat == CAT_OTHER || in_ch.end_of_text) ?
              FATE_EMIT : FATE_WRITE;
  end

  // Flush sequencing
  always_comb begin
    logic [PW-1:0] q;
    n_w      = PW'(cnt_r);
    found    = base_r || pend_r;
    reph_eff = found && reph_r;
    fl_moved = reph_eff || mpre_r;
    slot_free = !ov_r || out_ch.ready;
    ld       = (st_r == ST_FLUSH) && have_r && slot_free;
    more     = rpos_r < n_w;
    issue    = (st_r == ST_FLUSH) && more && (!have_r || ld);
    fl_done  = ld && !more;
    it_done  = (st_r == ST_ITEM) && slot_free;
    q = rpos_r + (reph_eff ? PW'(2) : PW'(0)) - (mpre_r ? PW'(1) : PW'(0));
    if (reph_eff && rpos_r >= n_w - PW'(2)) begin
      ix = rpos_r - (n_w - PW'(2));
    end else if (mpre_r && rpos_r == '0) begin
      ix = PW'(mpre_idx_r);
    end else if (mpre_r && q >= PW'(mpre_idx_r)) begin
      ix = q + PW'(1);
    end else begin
      ix = q;
    end
    rd_addr = ix[IDX_W-1:0];
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IN: begin
        if (acc) begin
          if (taken) st_nxt = in_ch.end_of_text ? ST_FLUSH : ST_IN;
          else if (ph_r != PH_IDLE) st_nxt = ST_FLUSH;
          else if (in_fate == FATE_EMIT) st_nxt = ST_ITEM;
          else st_nxt = ST_IN;
        end
      end
      ST_FLUSH: begin
        if (fl_done) st_nxt = (fate_r == FATE_EMIT) ? ST_ITEM : ST_IN;
      end
      ST_ITEM: begin
        if (it_done) st_nxt = ST_IN;
      end
      default: st_nxt = ST_IN;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    ph_nxt       = ph_r;
    cnt_nxt      = cnt_r;
    moved_nxt    = moved_r;
    hold_nxt     = hold_r;
    hold_cat_nxt = hold_cat_r;
    fate_nxt     = fate_r;
    eot_nxt      = eot_r;
    rpos_nxt     = rpos_r;
    have_nxt     = have_r;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = in_entry;
    app_en       = 1'b0;
    app_fresh    = 1'b0;
    app_cat      = in_cat;
    app_k        = cnt_r;
    ob_nxt       = ob_r;
    olast_nxt    = olast_r;
    oend_nxt     = oend_r;
    omoved_nxt   = omoved_r;
    ov_nxt       = out_ch.ready ? 1'b0 : ov_r;
    case (st_r)
      ST_IN: begin
        rpos_nxt = '0;
        have_nxt = 1'b0;
        if (acc) begin
          hold_nxt     = in_entry;
          hold_cat_nxt = in_cat;
          eot_nxt      = in_ch.end_of_text;
          if (taken) begin
            fate_nxt = FATE_NONE;
            wr_en    = 1'b1;
            wr_addr  = cnt_r[IDX_W-1:0];
            app_en   = 1'b1;
            cnt_nxt  = cnt_r + CNT_W'(1);
            ph_nxt   = cont_ph;
          end else begin
            fate_nxt = in_fate;
            if (ph_r == PH_IDLE && in_fate == FATE_WRITE) begin
              wr_en     = 1'b1;
              app_en    = 1'b1;
              app_fresh = 1'b1;
              app_k     = '0;
              cnt_nxt   = CNT_W'(1);
              ph_nxt    = start_phase(in_cat);
            end
          end
        end
      end
      ST_FLUSH: begin
        if (issue) begin
          rpos_nxt = rpos_r + PW'(1);
          have_nxt = 1'b1;
        end else if (ld) begin
          have_nxt = 1'b0;
        end
        if (ld) begin
          ov_nxt     = 1'b1;
          ob_nxt     = rdata_r;
          olast_nxt  = fl_done && (fate_r != FATE_EMIT);
          oend_nxt   = fl_done && (fate_r != FATE_EMIT) && eot_r;
          omoved_nxt = fl_done && (fate_r != FATE_EMIT) && eot_r && (moved_r || fl_moved);
        end
        if (fl_done) begin
          cnt_nxt   = '0;
          ph_nxt    = PH_IDLE;
          moved_nxt = (eot_r && fate_r != FATE_EMIT) ? 1'b0 : (moved_r || fl_moved);
          if (fate_r == FATE_WRITE) begin
            wr_en     = 1'b1;
            wr_data   = hold_r;
            app_en    = 1'b1;
            app_fresh = 1'b1;
            app_cat   = hold_cat_r;
            app_k     = '0;
            cnt_nxt   = CNT_W'(1);
            ph_nxt    = start_phase(hold_cat_r);
          end
        end
      end
      ST_ITEM: begin
        if (it_done) begin
          ov_nxt     = 1'b1;
          ob_nxt     = hold_r;
          olast_nxt  = 1'b1;
          oend_nxt   = eot_r;
          omoved_nxt = eot_r && moved_r;
          if (eot_r) begin
            moved_nxt = 1'b0;
            ph_nxt    = PH_IDLE;
            cnt_nxt   = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Incremental reorder tracking as characters are stored
  always_comb begin
    logic c_pend, c_base, c_mpre, base_now;
    c_pend = app_fresh ? 1'b0 : pend_r;
    c_base = app_fresh ? 1'b0 : base_r;
    c_mpre = app_fresh ? 1'b0 : mpre_r;
    base_now = c_base || (c_pend && app_cat != CAT_NUKTA && app_cat != CAT_VIRAMA);
    cat0ra_nxt   = cat0ra_r;
    cat1vir_nxt  = cat1vir_r;
    reph_nxt     = reph_r;
    pend_nxt     = pend_r;
    base_nxt     = base_r;
    mpre_nxt     = mpre_r;
    mpre_idx_nxt = mpre_idx_r;
    if (app_en) begin
      cat0ra_nxt  = (app_k == CNT_W'(0)) ? (app_cat == CAT_RA) : cat0ra_r;
      cat1vir_nxt = (app_k == CNT_W'(1)) ? (app_cat == CAT_VIRAMA) : cat1vir_r;
      reph_nxt    = (app_k == CNT_W'(2)) ? (cat0ra_r && cat1vir_r && is_cons(app_cat)) :
                    (app_fresh ? 1'b0 : reph_r);
      pend_nxt    = (c_pend && app_cat == CAT_NUKTA) || (!base_now && is_cons(app_cat));
      base_nxt    = base_now;
      mpre_nxt    = c_mpre || (base_now && app_cat == CAT_MPRE);
      if (base_now && !c_mpre && app_cat == CAT_MPRE) mpre_idx_nxt = app_k[IDX_W-1:0];
    end
  end

  // Syllable memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (issue) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IN;
      ph_r    <= PH_IDLE;
      cnt_r   <= '0;
      moved_r <= 1'b0;
      have_r  <= 1'b0;
      ov_r    <= 1'b0;
      fate_r  <= FATE_NONE;
      eot_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
      moved_r <= moved_nxt;
      have_r  <= have_nxt;
      ov_r    <= ov_nxt;
      fate_r  <= fate_nxt;
      eot_r   <= eot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cat0ra_r   <= cat0ra_nxt;
    cat1vir_r  <= cat1vir_nxt;
    reph_r     <= reph_nxt;
    pend_r     <= pend_nxt;
    base_r     <= base_nxt;
    mpre_r     <= mpre_nxt;
    mpre_idx_r <= mpre_idx_nxt;
    hold_r     <= hold_nxt;
    hold_cat_r <= hold_cat_nxt;
    rpos_r     <= rpos_nxt;
    ob_r       <= ob_nxt;
    olast_r    <= olast_nxt;
    oend_r     <= oend_nxt;
    omoved_r   <= omoved_nxt;
  end

  assign in_ch.ready              = (st_r == ST_IN);
  assign out_ch.valid             = ov_r;
  assign out_ch.out_code_point    = ob_r.code_point;
  assign out_ch.out_glyph_id      = ob_r.glyph_id;
  assign out_ch.out_advance       = ob_r.advance;
  assign out_ch.out_cluster_index = ob_r.cluster_index;
  assign out_ch.last_of_burst     = olast_r;
  assign out_ch.run_end           = oend_r;
  assign out_ch.run_moved         = omoved_r;

endmodule
